// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define CVPN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked around reset.
`define CVPN_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cvpn_pkg.sv =====
package cvpn_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // CORDIC working precision plus guard bits for gain growth.
  localparam int WORK_BITS = 40;
  localparam int CW        = WORK_BITS + 4;
  localparam int SCALE_SH  = WORK_BITS - SAMPLE_WIDTH;
  localparam int PH_SH     = WORK_BITS - FRAC_BITS;

  // Limiting inverse CORDIC gain, scaled by 2^WORK_BITS.
  localparam logic signed [CW-1:0] INV_GAIN = CW'(64'd667681663043);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {FRAC_BITS{1'b1}}};

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    last;
    logic    first;  // element opens a vector
    logic    zero;   // both parts are zero
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== sv/cvpn_fifo.sv =====
module cvpn_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  cvpn_pkg::item_t    wr_item,
  input  logic               rd_en,
  output cvpn_pkg::item_t    rd_item,
  output cvpn_pkg::fifo_stat_t stat
);
  import cvpn_pkg::*;

  item_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/cvpn_front.sv =====
module cvpn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cvpn_pkg::sample_t elem_re,
  input  cvpn_pkg::sample_t elem_im,
  input  logic              last_of_vector,
  input  logic              fifo_full,
  output logic              wr_en,
  output cvpn_pkg::item_t   wr_item
);
  import cvpn_pkg::*;

  logic at_vector_start;

  assign wr_en         = push && !fifo_full;
  assign wr_item.re    = elem_re;
  assign wr_item.im    = elem_im;
  assign wr_item.last  = last_of_vector;
  assign wr_item.first = at_vector_start;
  assign wr_item.zero  = (elem_re == '0) && (elem_im == '0);

  // The element after a last one opens the next vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_vector_start <= 1'b1;
    end else if (wr_en) begin
      at_vector_start <= last_of_vector;
    end
  end

endmodule

// ===== sv/cvpn_back.sv =====
module cvpn_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cvpn_pkg::fifo_stat_t fifo_stat,
  input  cvpn_pkg::item_t      rd_item,
  output logic                 rd_en,
  input  logic                 pop,
  output logic                 empty,
  output cvpn_pkg::sample_t    out_re,
  output cvpn_pkg::sample_t    out_im,
  output logic                 out_last
);
  import cvpn_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CORDIC = 3'd1;
  localparam logic [2:0] ST_PHASE  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;

  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam int SW1 = PW + 1;

  localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [CW-1:0] PH_HALF   = CW'(1) <<< (PH_SH - 1);
  localparam logic signed [CW-1:0] PH_MAX    = CW'(SMAX);
  localparam logic signed [CW-1:0] PH_MIN    = -PH_MAX;
  localparam logic signed [SW1-1:0] P_HALF   = SW1'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW1-1:0] O_MAX    = SW1'(SMAX);
  localparam logic signed [SW1-1:0] O_MIN    = -O_MAX - SW1'(1);

  logic [2:0]            state;
  logic [STEP_W-1:0]     step;
  sample_t               x_in;
  sample_t               y_in;
  logic                  last_w;
  logic signed [CW-1:0]  cx, cy, cpx, cpy;
  sample_t               ph_cos;
  sample_t               ph_sin;
  logic signed [PW-1:0]  prod_xc, prod_ys, prod_xs, prod_yc;
  logic                  ident;
  logic                  out_valid;

  logic signed [CW-1:0]  ext_x, ext_y;
  logic signed [CW-1:0]  sh_x, sh_y, sh_px, sh_py;
  logic signed [CW-1:0]  rnd_c, rnd_s;
  logic signed [SW1-1:0] sum_re, sum_im;
  sample_t               sat_re, sat_im;
  logic                  out_free;
  logic                  out_load;

  function automatic sample_t ph_clamp(input logic signed [CW-1:0] v);
    if (v > PH_MAX) begin
      return SMAX;
    end else if (v < PH_MIN) begin
      return -SMAX;
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic sample_t out_clamp(input logic signed [SW1-1:0] v);
    if (v > O_MAX) begin
      return SMAX;
    end else if (v < O_MIN) begin
      return -SMAX - 1'b1;
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  assign rd_en    = (state == ST_IDLE) && !fifo_stat.empty;
  assign out_free = !out_valid || pop;
  assign out_load = (state == ST_SUM) && out_free;

  always_comb begin
    ext_x  = CW'(rd_item.re) <<< SCALE_SH;
    ext_y  = CW'(rd_item.im) <<< SCALE_SH;
    sh_x   = cx >>> step;
    sh_y   = cy >>> step;
    sh_px  = cpx >>> step;
    sh_py  = cpy >>> step;
    rnd_c  = (cpx + PH_HALF) >>> PH_SH;
    rnd_s  = (cpy + PH_HALF) >>> PH_SH;
    sum_re = (SW1'(prod_xc) - SW1'(prod_ys) + P_HALF) >>> FRAC_BITS;
    sum_im = (SW1'(prod_xs) + SW1'(prod_yc) + P_HALF) >>> FRAC_BITS;
    sat_re = out_clamp(sum_re);
    sat_im = out_clamp(sum_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ph_cos    <= SMAX;
      ph_sin    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rd_en) begin
            x_in   <= rd_item.re;
            y_in   <= rd_item.im;
            last_w <= rd_item.last;
            step   <= '0;
            cpy    <= '0;
            if (rd_item.first && rd_item.zero) begin
              ph_cos <= SMAX;
              ph_sin <= '0;
              state  <= ST_MUL;
            end else if (rd_item.first) begin
              // Fold the left half plane over; flip the phasor seed with it.
              if (rd_item.re[SAMPLE_WIDTH-1]) begin
                cx  <= -ext_x;
                cy  <= -ext_y;
                cpx <= -INV_GAIN;
              end else begin
                cx  <= ext_x;
                cy  <= ext_y;
                cpx <= INV_GAIN;
              end
              state <= ST_CORDIC;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_CORDIC: begin
          if (!cy[CW-1]) begin
            cx  <= cx + sh_y;
            cy  <= cy - sh_x;
            cpx <= cpx + sh_py;
            cpy <= cpy - sh_px;
          end else begin
            cx  <= cx - sh_y;
            cy  <= cy + sh_x;
            cpx <= cpx - sh_py;
            cpy <= cpy + sh_px;
          end
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          ph_cos <= ph_clamp(rnd_c);
          ph_sin <= ph_clamp(rnd_s);
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod_xc <= x_in * ph_cos;
          prod_ys <= y_in * ph_sin;
          prod_xs <= x_in * ph_sin;
          prod_yc <= y_in * ph_cos;
          ident   <= (ph_cos == SMAX) && (ph_sin == '0);
          state   <= ST_SUM;
        end
        ST_SUM: begin
          // Hold here until the result register frees up.
          if (out_free) begin
            out_re    <= ident ? x_in : sat_re;
            out_im    <= ident ? y_in : sat_im;
            out_last  <= last_w;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty = !out_valid;

endmodule

// ===== sv/complex_vector_phase_normalizer_top.sv =====
// An element inside a vector is read from the queue, rotated by its vector's phasor,
// then rounded, saturated and loaded into the result register; a vector's first
// element first sets the phasor, by the one-step-per-cycle CORDIC loop unless zero.
// The back reads the next element only after loading the last, which waits while a result is held.
// Reset (synchronous, rst high) empties the queue and the result register and
// makes the next element open a new vector.
module complex_vector_phase_normalizer_top (
  input  logic              clk,
  input  logic              rst,
  // Input side, queue style: transfer when push is high and full is low.
  input  logic              push,
  output logic              full,
  input  cvpn_pkg::sample_t elem_re,
  input  cvpn_pkg::sample_t elem_im,
  input  logic              last_of_vector,
  // Result side: transfer when pop is high and empty is low.
  input  logic              pop,
  output logic              empty,
  output cvpn_pkg::sample_t out_re,
  output cvpn_pkg::sample_t out_im,
  output logic              out_last
);
  import cvpn_pkg::*;

  logic       wr_en;
  item_t      wr_item;
  logic       rd_en;
  item_t      rd_item;
  fifo_stat_t fifo_stat;

  // Front: tag each element as vector start and as zero, then queue it.
  cvpn_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .elem_re        (elem_re),
    .elem_im        (elem_im),
    .last_of_vector (last_of_vector),
    .fifo_full      (fifo_stat.full),
    .wr_en          (wr_en),
    .wr_item        (wr_item)
  );

  // Short queue so the front keeps taking elements while the back runs
  // the CORDIC for a new vector.
  cvpn_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .rd_item (rd_item),
    .stat    (fifo_stat)
  );

  // Back: derive the phasor on a vector start, rotate, round, saturate,
  // and hold the result in the output register until it is popped.
  cvpn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .rd_item   (rd_item),
    .rd_en     (rd_en),
    .pop       (pop),
    .empty     (empty),
    .out_re    (out_re),
    .out_im    (out_im),
    .out_last  (out_last)
  );

  assign full = fifo_stat.full;

endmodule

// ===== sv/cvpn_checker.sv =====
`include "assert_macros.svh"

module cvpn_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input cvpn_pkg::sample_t out_re,
  input cvpn_pkg::sample_t out_im,
  input logic              out_last
);

  // A waiting result stays until it is popped.
  `CVPN_ASSERT(a_result_held, (!empty && !pop) |=> !empty, "result dropped without pop")

  `CVPN_ASSERT(a_result_stable, (!empty && !pop) |=> $stable({out_re, out_im, out_last}), "result changed")

  // Reset drops the result register and the queue.
  `CVPN_ASSERT_NORST(a_reset_empty, rst |=> empty, "result present after reset")

  `CVPN_ASSERT_NORST(a_reset_not_full, rst |=> !full, "queue full after reset")

endmodule

bind complex_vector_phase_normalizer_top cvpn_checker u_cvpn_checker (.*);
